### hdl/ptd_pkg.sv
// Shared types and constants for the priority task dispatcher.
package ptd_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int ID_W          = 16;
	localparam int PRIO_W        = 8;
	localparam int BURST_W       = 16;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_SCHED = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCEPT   = 2'd0,
		ST_DISPATCH = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} entry_t;

endpackage

### hdl/priority_task_dispatcher.sv
// Non-preemptive priority dispatcher: task table, add and drain sequencer.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, command, priority_in,    | request in
//          | burst_in                                     |
//  out     | out_valid, out_ready, status, task_id,       | result out
//          | out_priority, out_burst, last                |
//
// An add loads its result from S_ADD once the output register is free. A
// schedule of N stored tasks gives N results; for each one a compare unit
// walks the single table read port newest to oldest, one entry per cycle.
// arst_n clears the task count, next id and the dispatched marks; table
// contents need no reset. A stalled out_ready holds the sequencer in S_ADD or
// S_EMIT until the output register frees; in_ready is high only in S_IDLE.
module priority_task_dispatcher #(
	parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [ptd_pkg::PRIO_W-1:0]  priority_in,
	input  logic [ptd_pkg::BURST_W-1:0] burst_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [ptd_pkg::ID_W-1:0]    task_id,
	output logic [ptd_pkg::PRIO_W-1:0]  out_priority,
	output logic [ptd_pkg::BURST_W-1:0] out_burst,
	output logic                        last
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	ptd_pkg::state_t state_q, state_d;

	// request holding registers
	logic                        cmd_q;
	logic [ptd_pkg::PRIO_W-1:0]  prio_q;
	logic [ptd_pkg::BURST_W-1:0] burst_q;

	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            rem_q;
	logic [ptd_pkg::ID_W-1:0]    next_id_q;
	logic [MAX_TASKS-1:0]        taken_q;

	// scan sequencer
	logic [IDX_W-1:0]            scan_idx_q;
	logic                        scan_act_q;
	logic                        s1_vld_q;
	logic                        s1_live_q;
	logic                        s1_end_q;
	logic [IDX_W-1:0]            s1_idx_q;
	logic                        best_found_q;
	ptd_pkg::entry_t             best_q;
	logic [IDX_W-1:0]            best_idx_q;

	// output register
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [ptd_pkg::ID_W-1:0]    task_id_q;
	logic [ptd_pkg::PRIO_W-1:0]  out_prio_q;
	logic [ptd_pkg::BURST_W-1:0] out_burst_q;
	logic                        last_q;

	ptd_pkg::entry_t             wr_entry;
	ptd_pkg::entry_t             rd_entry;
	logic                        in_acc;
	logic                        out_free;
	logic                        out_load;
	logic                        ram_we;
	logic                        ram_re;
	logic                        start_scan;
	logic                        is_full;
	logic                        take_best;
	logic [CNT_W-1:0]            count_m1;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign is_full  = (count_q == FULL_CNT);
	assign count_m1 = count_q - ONE_CNT;

	assign wr_entry.id    = next_id_q;
	assign wr_entry.prio  = prio_q;
	assign wr_entry.burst = burst_q;

	assign take_best = s1_vld_q && s1_live_q &&
		(!best_found_q || (rd_entry.prio > best_q.prio));

	ptd_ram #(
		.WIDTH ($bits(ptd_pkg::entry_t)),
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (scan_idx_q),
		.rdata (rd_entry)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptd_pkg::S_IDLE: begin
				if (in_acc) begin
					if (command == ptd_pkg::CMD_ADD) begin
						state_d = ptd_pkg::S_ADD;
					end else if (count_q != '0) begin
						state_d = ptd_pkg::S_SCAN;
					end
				end
			end
			ptd_pkg::S_ADD: begin
				if (out_free) begin
					state_d = ptd_pkg::S_IDLE;
				end
			end
			ptd_pkg::S_SCAN: begin
				if (s1_vld_q && s1_end_q) begin
					state_d = ptd_pkg::S_EMIT;
				end
			end
			ptd_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = (rem_q == ONE_CNT) ? ptd_pkg::S_IDLE : ptd_pkg::S_SCAN;
				end
			end
			default: state_d = ptd_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		out_load   = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		start_scan = 1'b0;
		case (state_q)
			ptd_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				start_scan = in_acc && (command == ptd_pkg::CMD_SCHED) && (count_q != '0);
			end
			ptd_pkg::S_ADD: begin
				out_load = out_free;
				ram_we   = out_free && !is_full;
			end
			ptd_pkg::S_SCAN: begin
				ram_re = scan_act_q;
			end
			ptd_pkg::S_EMIT: begin
				out_load   = out_free;
				start_scan = out_free && (rem_q != ONE_CNT);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ptd_pkg::S_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			next_id_q    <= '0;
			taken_q      <= '0;
			scan_act_q   <= 1'b0;
			s1_vld_q     <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			s1_vld_q <= ram_re;

			if (in_acc && (command == ptd_pkg::CMD_SCHED)) begin
				rem_q <= count_q;
			end

			if (ram_we) begin
				count_q   <= count_q + ONE_CNT;
				next_id_q <= next_id_q + ptd_pkg::ID_W'(1);
			end

			// walk the table newest to oldest
			if (start_scan) begin
				scan_act_q   <= 1'b1;
				best_found_q <= 1'b0;
			end else if (ram_re && (scan_idx_q == '0)) begin
				scan_act_q <= 1'b0;
			end

			if (take_best) begin
				best_found_q <= 1'b1;
			end

			// dispatch: mark the winner; drop the whole table after the final one
			if ((state_q == ptd_pkg::S_EMIT) && out_free) begin
				if (rem_q == ONE_CNT) begin
					taken_q <= '0;
					count_q <= '0;
				end else begin
					taken_q[best_idx_q] <= 1'b1;
					rem_q               <= rem_q - ONE_CNT;
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= command;
			prio_q  <= priority_in;
			burst_q <= burst_in;
		end

		if (start_scan) begin
			scan_idx_q <= count_m1[IDX_W-1:0];
		end else if (ram_re) begin
			scan_idx_q <= scan_idx_q - IDX_W'(1);
		end

		s1_idx_q  <= scan_idx_q;
		s1_live_q <= !taken_q[scan_idx_q];
		s1_end_q  <= (scan_idx_q == '0);

		if (take_best) begin
			best_q     <= rd_entry;
			best_idx_q <= s1_idx_q;
		end

		if (out_load) begin
			if (state_q == ptd_pkg::S_ADD) begin
				status_q    <= is_full ? ptd_pkg::ST_FULL : ptd_pkg::ST_ACCEPT;
				task_id_q   <= is_full ? '0 : next_id_q;
				out_prio_q  <= prio_q;
				out_burst_q <= burst_q;
				last_q      <= 1'b1;
			end else begin
				status_q    <= ptd_pkg::ST_DISPATCH;
				task_id_q   <= best_q.id;
				out_prio_q  <= best_q.prio;
				out_burst_q <= best_q.burst;
				last_q      <= (rem_q == ONE_CNT);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign task_id      = task_id_q;
	assign out_priority = out_prio_q;
	assign out_burst    = out_burst_q;
	assign last         = last_q;

	// the add path only runs off a latched add request
	a_add_from_add_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptd_pkg::S_ADD) |-> (cmd_q == ptd_pkg::CMD_ADD))
		else $error("add sequence entered without an add request");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("task count above table size");

	a_sched_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == ptd_pkg::CMD_SCHED) && (count_q != '0)) |=> !in_ready)
		else $error("new request taken while table drains");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last && (status == ptd_pkg::ST_DISPATCH))
			|-> (count_q == '0))
		else $error("table not empty after final dispatch");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ptd_pkg::ST_FULL)) |-> is_full)
		else $error("full status with room in the table");

endmodule

### hdl/ptd_ram.sv
// Generic simple dual-port RAM with registered read.
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
